@@ rtl/dbh_pkg.sv @@
// Shared types, codes and reset values for the button/switch debounce block.
package dbh_pkg;

    localparam int STABLE_SAMPLES_DEF   = 3;
    localparam int HOLD_COUNT_WIDTH_DEF = 16;

    localparam int STATUS_W    = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;
    localparam int HOLD_CFG_W  = 16;
    localparam int DIV_W       = 8;

    localparam logic [HOLD_CFG_W-1:0] HOLD_SAMPLES_RST   = 16'd100;
    localparam logic [DIV_W-1:0]      SAMPLE_DIVIDER_RST = 8'd10;

    typedef enum logic [STATUS_W-1:0] {
        CODE_NO_PRESSED = 3'd0,
        CODE_PRESSED    = 3'd1,
        CODE_ON_HOLD    = 3'd2,
        CODE_SW_OFF     = 3'd3,
        CODE_SW_ON      = 3'd4
    } t_code;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MODE           = 2'd0,
        REG_ACTIVE_LEVEL   = 2'd1,
        REG_HOLD_SAMPLES   = 2'd2,
        REG_SAMPLE_DIVIDER = 2'd3
    } t_reg_index;

    localparam logic FUNC_TICK = 1'b0;
    localparam logic MODE_BUTTON = 1'b0;

    typedef struct packed {
        t_code status;
        logic  changed;
    } t_result;

endpackage

@@ rtl/dbh_core.sv @@
// Debounce state, hold countdown, prescaler and config registers; one request per cycle when i_fire is high.
module dbh_core #(
    parameter int STABLE_SAMPLES   = dbh_pkg::STABLE_SAMPLES_DEF,
    parameter int HOLD_COUNT_WIDTH = dbh_pkg::HOLD_COUNT_WIDTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_fire,
    input  logic                       i_func,
    input  logic                       i_pin_level,
    input  logic                       i_cfg_wr_en,
    input  logic [dbh_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [dbh_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    output dbh_pkg::t_result           o_result
);
    import dbh_pkg::*;

    localparam logic [STABLE_SAMPLES-1:0]   HIST_ONES = {STABLE_SAMPLES{1'b1}};
    localparam logic [HOLD_COUNT_WIDTH-1:0] CD_ZERO   = '0;

    logic                        r_mode, n_mode;
    logic                        r_active, n_active;
    logic [HOLD_CFG_W-1:0]       r_hold, n_hold;
    logic [DIV_W-1:0]            r_div, n_div;
    logic [STABLE_SAMPLES-1:0]   r_hist, n_hist;
    logic                        r_stable, n_stable;
    logic [HOLD_COUNT_WIDTH-1:0] r_cd, n_cd;
    t_code                       r_cur, n_cur;
    t_code                       r_last, n_last;
    logic [DIV_W-1:0]            r_presc, n_presc;

    logic                        reinit;
    logic [DIV_W-1:0]            presc_inc;
    logic                        sample;
    logic [STABLE_SAMPLES-1:0]   hist_shift;
    logic [HOLD_COUNT_WIDTH-1:0] cd_dec;
    t_code                       code_dec;
    logic                        agree;
    logic                        lvl;

    assign presc_inc  = r_presc + 1'b1;
    assign sample     = (presc_inc == r_div);
    assign hist_shift = {r_hist[STABLE_SAMPLES-2:0], i_pin_level};
    assign agree      = (hist_shift == '0) || (hist_shift == HIST_ONES);
    assign lvl        = hist_shift[0];

    // countdown steps before the debounce decision, as the release test uses it
    always_comb begin
        cd_dec   = r_cd;
        code_dec = r_cur;
        if (r_mode == MODE_BUTTON && r_cd != CD_ZERO) begin
            cd_dec = r_cd - 1'b1;
            if (cd_dec == CD_ZERO) begin
                code_dec = CODE_ON_HOLD;
            end
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_active = r_active;
        n_hold   = r_hold;
        n_div    = r_div;
        n_hist   = r_hist;
        n_stable = r_stable;
        n_cd     = r_cd;
        n_cur    = r_cur;
        n_last   = r_last;
        n_presc  = r_presc;
        reinit   = 1'b0;

        if (i_cfg_wr_en) begin
            case (t_reg_index'(i_cfg_index))
                REG_MODE: begin
                    n_mode = i_cfg_data[0];
                    reinit = 1'b1;
                end
                REG_ACTIVE_LEVEL: begin
                    n_active = i_cfg_data[0];
                    reinit   = 1'b1;
                end
                REG_HOLD_SAMPLES:   n_hold = i_cfg_data[HOLD_CFG_W-1:0];
                REG_SAMPLE_DIVIDER: n_div  = i_cfg_data[DIV_W-1:0];
                default: ;
            endcase
        end

        if (reinit) begin
            n_hist   = n_active ? '0 : HIST_ONES;
            n_stable = ~n_active;
            n_cd     = CD_ZERO;
            n_cur    = n_mode ? CODE_SW_OFF : CODE_NO_PRESSED;
            n_last   = n_cur;
        end else if (i_fire) begin
            if (i_func != FUNC_TICK) begin
                n_cur  = (r_cur == CODE_PRESSED) ? CODE_NO_PRESSED : r_cur;
                n_last = n_cur;
            end else if (sample) begin
                n_presc = '0;
                n_hist  = hist_shift;
                n_cd    = cd_dec;
                n_cur   = code_dec;
                if (agree && lvl != r_stable) begin
                    n_stable = lvl;
                    if (r_mode == MODE_BUTTON) begin
                        if (lvl == r_active) begin
                            n_cd = HOLD_COUNT_WIDTH'(r_hold);
                        end else begin
                            n_cur = (cd_dec != CD_ZERO) ? CODE_PRESSED : CODE_NO_PRESSED;
                            n_cd  = CD_ZERO;
                        end
                    end else begin
                        n_cur = (lvl == r_active) ? CODE_SW_ON : CODE_SW_OFF;
                    end
                end
            end else begin
                n_presc = presc_inc;
            end
        end
    end

    // a read reports the state before it is updated; a tick reports after
    always_comb begin
        if (i_func != FUNC_TICK) begin
            o_result.status  = r_cur;
            o_result.changed = (r_cur != r_last);
        end else begin
            o_result.status  = n_cur;
            o_result.changed = (n_cur != r_last);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_BUTTON;
            r_active <= 1'b0;
            r_hold   <= HOLD_SAMPLES_RST;
            r_div    <= SAMPLE_DIVIDER_RST;
            r_hist   <= HIST_ONES;
            r_stable <= 1'b1;
            r_cd     <= CD_ZERO;
            r_cur    <= CODE_NO_PRESSED;
            r_last   <= CODE_NO_PRESSED;
            r_presc  <= '0;
        end else begin
            r_mode   <= n_mode;
            r_active <= n_active;
            r_hold   <= n_hold;
            r_div    <= n_div;
            r_hist   <= n_hist;
            r_stable <= n_stable;
            r_cd     <= n_cd;
            r_cur    <= n_cur;
            r_last   <= n_last;
            r_presc  <= n_presc;
        end
    end

endmodule

@@ rtl/dbh_out_reg.sv @@
// Result register holding one finished request until the consumer takes it.
module dbh_out_reg (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  dbh_pkg::t_result i_result,
    input  logic             i_stall,
    output logic             o_valid,
    output logic             o_full_stalled,
    output dbh_pkg::t_result o_result
);
    import dbh_pkg::*;

    logic    r_valid, n_valid;
    t_result r_result, n_result;

    assign o_full_stalled = r_valid & i_stall;

    always_comb begin
        n_valid  = r_valid;
        n_result = r_result;
        if (i_load) begin
            n_valid  = 1'b1;
            n_result = i_result;
        end else if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        r_result <= n_result;
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

@@ rtl/button_switch_debounce_hold_top.sv @@
// Top level of the one-pin debouncer with hold detection and switch reporting.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+---------------------------------
//  request | in        | i_valid / o_stall | i_func, i_pin_level
//  result  | out       | o_valid / i_stall | o_status, o_changed
//  config  | in        | i_cfg_wr_en       | i_cfg_index, i_cfg_data
//
// One request per cycle while o_stall is low; its result appears in the output register the next cycle.
// The state update is one pass of logic between the state registers and the result register.
// o_stall rises only while a result is held and i_stall is high.
// Synchronous active-low reset restores config and debounce state; no clearing pass.
module button_switch_debounce_hold_top #(
    parameter int STABLE_SAMPLES   = dbh_pkg::STABLE_SAMPLES_DEF,
    parameter int HOLD_COUNT_WIDTH = dbh_pkg::HOLD_COUNT_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_func,
    input  logic                            i_pin_level,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [dbh_pkg::STATUS_W-1:0]    o_status,
    output logic                            o_changed,
    input  logic                            i_cfg_wr_en,
    input  logic [dbh_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [dbh_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import dbh_pkg::*;

    logic    fire;
    t_result core_result;
    t_result out_result;

    assign fire = i_valid & ~o_stall;

    dbh_core #(
        .STABLE_SAMPLES  (STABLE_SAMPLES),
        .HOLD_COUNT_WIDTH(HOLD_COUNT_WIDTH)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_func     (i_func),
        .i_pin_level(i_pin_level),
        .i_cfg_wr_en(i_cfg_wr_en),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data),
        .o_result   (core_result)
    );

    dbh_out_reg u_out_reg (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (fire),
        .i_result      (core_result),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_full_stalled(o_stall),
        .o_result      (out_result)
    );

    assign o_status  = out_result.status;
    assign o_changed = out_result.changed;

endmodule

@@ rtl/dbh_checker.sv @@
// Port-level checks on the debounce block, bound to the top level.
module dbh_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_valid,
    input logic                            o_stall,
    input logic                            o_valid,
    input logic                            i_stall,
    input logic [dbh_pkg::STATUS_W-1:0]    o_status,
    input logic                            o_changed
);
    import dbh_pkg::*;

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status <= CODE_SW_ON))
        else $error("status code out of range");

    a_accept_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_valid)
        else $error("accepted request produced no result");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("input stalled while result register free");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status) && $stable(o_changed)))
        else $error("stalled result changed");

endmodule

bind button_switch_debounce_hold_top dbh_checker u_dbh_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (i_valid),
    .o_stall  (o_stall),
    .o_valid  (o_valid),
    .i_stall  (i_stall),
    .o_status (o_status),
    .o_changed(o_changed)
);
